@@ rtl/fico_pkg.sv @@
// Shared types, constants and helper functions for the chunked offset generator.
`timescale 1ns / 1ps
package fico_pkg;

  // Number of descriptor slots and the width of a slot number.
  localparam int MAX_DIMS = 4;
  localparam int SLOT_W   = 2;

  // Register stages inside one dimension section.
  localparam int SEC_STAGES = 18;

  // Request operation codes.
  localparam logic OP_LOAD    = 1'b0;
  localparam logic OP_COMPUTE = 1'b1;

  // One request as it travels from section to section.
  typedef struct packed {
    logic              vld;
    logic              op;
    logic [SLOT_W-1:0] slot;
    logic [15:0]       ext;
    logic [15:0]       chk;
    logic [31:0]       outer;
    logic [31:0]       inner;
    logic [31:0]       rem;
    logic [31:0]       sum;
  } item_t;

  // Four steps of restoring division: returns the new partial remainder
  // in bits 19..4 and the four quotient bits in bits 3..0.
  function automatic logic [19:0] div_step4(input logic [15:0] r_in,
                                            input logic [3:0]  bits,
                                            input logic [15:0] den);
    logic [16:0] t;
    logic [15:0] r;
    logic [3:0]  q;
    r = r_in;
    q = 4'd0;
    for (int i = 3; i >= 0; i--) begin
      t = {r, bits[i]};
      if (t >= {1'b0, den}) begin
        t    = t - {1'b0, den};
        q[i] = 1'b1;
      end
      r = t[15:0];
    end
    return {r, q};
  endfunction

endpackage

@@ rtl/fico_dim.sv @@
// One dimension section: coordinate split, chunk split and stride products.
`timescale 1ns / 1ps
module fico_dim (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [fico_pkg::SLOT_W-1:0] slot_id,
  input  logic                        act,
  input  fico_pkg::item_t             in_item,
  output fico_pkg::item_t             out_item
);

  typedef struct packed {
    fico_pkg::item_t it;
    logic [31:0]     q;
    logic [15:0]     r;
    logic [31:0]     d;
    logic [31:0]     nrem;
    logic [31:0]     p1;
    logic [31:0]     p2;
  } stg_t;

  localparam int NS = fico_pkg::SEC_STAGES;

  stg_t        st_r   [0:NS-1];
  stg_t        st_nxt [0:NS-1];
  logic [15:0] ext_r;
  logic [15:0] chk_r;
  logic [31:0] outer_r;
  logic [31:0] inner_r;

  // Descriptor of this slot, written when a load request passes the entry.
  always_ff @(posedge clk) begin
    if (in_item.vld && in_item.op == fico_pkg::OP_LOAD && in_item.slot == slot_id) begin
      ext_r   <= in_item.ext;
      chk_r   <= in_item.chk;
      outer_r <= in_item.outer;
      inner_r <= in_item.inner;
    end
  end

  // Entry: a compute request picks up the descriptor so later loads cannot disturb it.
  always_comb begin
    st_nxt[0]    = '0;
    st_nxt[0].it = in_item;
    if (in_item.op == fico_pkg::OP_COMPUTE) begin
      st_nxt[0].it.ext   = ext_r;
      st_nxt[0].it.chk   = chk_r;
      st_nxt[0].it.outer = outer_r;
      st_nxt[0].it.inner = inner_r;
    end
  end

  genvar s;
  generate
    for (s = 0; s < NS - 1; s++) begin : g_stage
      if (s < 8) begin : g_diva
        // Index divided by the extent, four quotient bits per stage.
        logic [19:0] res;
        always_comb begin
          res = fico_pkg::div_step4(st_r[s].r, st_r[s].it.rem[31-4*s -: 4], st_r[s].it.ext);
          st_nxt[s+1]   = st_r[s];
          st_nxt[s+1].r = res[19:4];
          st_nxt[s+1].q[31-4*s -: 4] = res[3:0];
        end
      end else if (s < 16) begin : g_divb
        // Coordinate divided by the chunk extent.
        logic [31:0] coord;
        logic [15:0] r_in;
        logic [19:0] res;
        always_comb begin
          st_nxt[s+1] = st_r[s];
          if (s == 8) begin
            if (st_r[s].it.ext == 16'd0) begin
              coord              = st_r[s].it.rem;
              st_nxt[s+1].nrem   = 32'd0;
            end else begin
              coord              = {16'd0, st_r[s].r};
              st_nxt[s+1].nrem   = st_r[s].q;
            end
            r_in = 16'd0;
            st_nxt[s+1].q = 32'd0;
          end else begin
            coord = st_r[s].d;
            r_in  = st_r[s].r;
          end
          res = fico_pkg::div_step4(r_in, coord[31-4*(s-8) -: 4], st_r[s].it.chk);
          st_nxt[s+1].d = coord;
          st_nxt[s+1].r = res[19:4];
          st_nxt[s+1].q[31-4*(s-8) -: 4] = res[3:0];
        end
      end else begin : g_mul
        // Chunk number and position scaled by their strides.
        logic [31:0] cidx;
        logic [31:0] pos;
        always_comb begin
          if (st_r[s].it.chk == 16'd0) begin
            cidx = 32'd0;
            pos  = st_r[s].d;
          end else begin
            cidx = st_r[s].q;
            pos  = {16'd0, st_r[s].r};
          end
          st_nxt[s+1]    = st_r[s];
          st_nxt[s+1].p1 = cidx * st_r[s].it.outer;
          st_nxt[s+1].p2 = pos * st_r[s].it.inner;
        end
      end
    end
  endgenerate

  // Stage registers; only the valid bits are reset.
  always_ff @(posedge clk) begin
    for (int i = 0; i < NS; i++) begin
      if (!rst_n) begin
        st_r[i].it.vld <= 1'b0;
      end else begin
        st_r[i] <= st_nxt[i];
      end
    end
  end

  // Exit: for an active compute, accumulate the products and pass on the remaining index.
  always_comb begin
    out_item = st_r[NS-1].it;
    if (act && st_r[NS-1].it.op == fico_pkg::OP_COMPUTE) begin
      out_item.sum = st_r[NS-1].it.sum + st_r[NS-1].p1 + st_r[NS-1].p2;
      out_item.rem = st_r[NS-1].nrem;
    end
  end

endmodule

@@ rtl/flat_index_to_chunked_offset.sv @@
// Top level of the chunked strided offset generator.
`timescale 1ns / 1ps
// Usage:
// A request is taken at a rising edge where start is high and busy is low.
// busy stays low, so a request may be given in every cycle.
// in_op selects a descriptor load (slot, extents and two signed strides)
// or an offset computation on in_flat_index.
// A compute request yields one result: out_valid is high for exactly one
// cycle with out_offset. Load requests yield no result. Results come in
// request order.
// The pipeline is four dimension sections of 18 stages each, innermost slot
// first, plus an output register; each section divides in four-bit steps.
// Loads travel down the pipeline and update each section's descriptor as
// they pass it, so a compute sees exactly the loads taken before it.
// cfg_we writes active_dims from cfg_wdata; write it only while idle.
// Synchronous reset clears the valid bits and active_dims; descriptors stay
// undefined until loaded. The receiver cannot stall the result.
module flat_index_to_chunked_offset (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic                        in_op,
  input  logic [fico_pkg::SLOT_W-1:0] in_dim_slot,
  input  logic [15:0]                 in_dim_extent,
  input  logic [15:0]                 in_chunk_extent,
  input  logic signed [31:0]          in_outer_stride,
  input  logic signed [31:0]          in_inner_stride,
  input  logic [31:0]                 in_flat_index,
  output logic                        out_valid,
  output logic [31:0]                 out_offset,
  input  logic                        cfg_we,
  input  logic [2:0]                  cfg_wdata
);

  fico_pkg::item_t chain [0:fico_pkg::MAX_DIMS];
  logic [2:0]      active_dims_r;
  logic            out_valid_r;
  logic [31:0]     out_offset_r;

  // The pipeline never holds off a request.
  assign busy = 1'b0;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_dims_r <= 3'd0;
    end else if (cfg_we) begin
      active_dims_r <= cfg_wdata;
    end
  end

  // Incoming request.
  always_comb begin
    chain[0].vld   = start && !busy;
    chain[0].op    = in_op;
    chain[0].slot  = in_dim_slot;
    chain[0].ext   = in_dim_extent;
    chain[0].chk   = in_chunk_extent;
    chain[0].outer = in_outer_stride;
    chain[0].inner = in_inner_stride;
    chain[0].rem   = in_flat_index;
    chain[0].sum   = 32'd0;
  end

  // Dimension sections, innermost slot first.
  genvar g;
  generate
    for (g = 0; g < fico_pkg::MAX_DIMS; g++) begin : g_dim
      localparam logic [fico_pkg::SLOT_W-1:0] SLOT =
        fico_pkg::SLOT_W'(fico_pkg::MAX_DIMS - 1 - g);
      fico_dim u_dim (
        .clk      (clk),
        .rst_n    (rst_n),
        .slot_id  (SLOT),
        .act      ({1'b0, SLOT} < active_dims_r),
        .in_item  (chain[g]),
        .out_item (chain[g+1])
      );
    end
  endgenerate

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= chain[fico_pkg::MAX_DIMS].vld &&
                     chain[fico_pkg::MAX_DIMS].op == fico_pkg::OP_COMPUTE;
    end
    out_offset_r <= chain[fico_pkg::MAX_DIMS].sum;
  end

  assign out_valid  = out_valid_r;
  assign out_offset = out_offset_r;

endmodule

@@ bench/tb_top.sv @@
// Self-checking testbench for the chunked strided offset generator.
`timescale 1ns / 1ps
module tb_top;

  // Wait after the last request before a register write, so loads leave the pipeline.
  localparam int DRAIN_CYCLES = 80;
  localparam int WATCHDOG_LIMIT = 5000;

  typedef enum logic [1:0] {K_REQ, K_CFG, K_PAUSE, K_GAP} entry_kind_t;

  typedef struct {
    entry_kind_t kind;
    logic        op;
    logic [1:0]  slot;
    logic [15:0] ext;
    logic [15:0] chk;
    logic [31:0] outer;
    logic [31:0] inner;
    logic [31:0] flat;
    int          val;
  } entry_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic in_op = 1'b0;
  logic [1:0] in_dim_slot = '0;
  logic [15:0] in_dim_extent = '0;
  logic [15:0] in_chunk_extent = '0;
  logic signed [31:0] in_outer_stride = '0;
  logic signed [31:0] in_inner_stride = '0;
  logic [31:0] in_flat_index = '0;
  logic out_valid;
  logic [31:0] out_offset;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_wdata = '0;

  entry_t      pending_q[$];
  logic [31:0] offset_q[$];
  int          errors = 0;
  int          gap_pct = 0;
  int          idle_cyc = 0;
  int          stall_cyc = 0;

  // Predictor copy of the descriptor table and the register.
  logic [15:0] ext_tab[4];
  logic [15:0] chk_tab[4];
  logic [31:0] outer_tab[4];
  logic [31:0] inner_tab[4];
  logic [2:0]  dims_reg = '0;

  flat_index_to_chunked_offset DUT (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_op(in_op), .in_dim_slot(in_dim_slot), .in_dim_extent(in_dim_extent),
    .in_chunk_extent(in_chunk_extent), .in_outer_stride(in_outer_stride),
    .in_inner_stride(in_inner_stride), .in_flat_index(in_flat_index),
    .out_valid(out_valid), .out_offset(out_offset),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // Mixed-radix decode, innermost active slot first, summed modulo 2^32.
  function automatic logic [31:0] chunked_offset(logic [31:0] flat);
    logic [31:0] rem, sum, coord, cidx, pos;
    int n;
    rem = flat;
    sum = '0;
    n = (dims_reg > 3'd4) ? 4 : int'(dims_reg);
    for (int k = n - 1; k >= 0; k--) begin
      if (ext_tab[k] == 16'd0) begin
        coord = rem;
        rem = '0;
      end else begin
        coord = rem % {16'd0, ext_tab[k]};
        rem = rem / {16'd0, ext_tab[k]};
      end
      if (chk_tab[k] == 16'd0) begin
        cidx = '0;
        pos = coord;
      end else begin
        cidx = coord / {16'd0, chk_tab[k]};
        pos = coord % {16'd0, chk_tab[k]};
      end
      sum = sum + cidx * outer_tab[k] + pos * inner_tab[k];
    end
    return sum;
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("MISMATCH %s: got %h expected %h at %0t", what, got, want, $time);
    errors++;
  endtask

  task automatic push_load(logic [1:0] slot, logic [15:0] ext, logic [15:0] chk,
                           logic [31:0] outer, logic [31:0] inner);
    entry_t e;
    e = '{kind: K_REQ, op: fico_pkg::OP_LOAD, slot: slot, ext: ext, chk: chk,
          outer: outer, inner: inner, flat: $urandom, val: 0};
    pending_q.push_back(e);
  endtask

  task automatic push_compute(logic [31:0] flat);
    entry_t e;
    e = '{kind: K_REQ, op: fico_pkg::OP_COMPUTE, slot: 2'($urandom),
          ext: 16'($urandom), chk: 16'($urandom), outer: $urandom,
          inner: $urandom, flat: flat, val: 0};
    pending_q.push_back(e);
  endtask

  task automatic push_ctrl(entry_kind_t kind, int val);
    entry_t e;
    e = '{kind: kind, op: 1'b0, slot: '0, ext: '0, chk: '0, outer: '0, inner: '0,
          flat: '0, val: val};
    pending_q.push_back(e);
  endtask

  function automatic logic [15:0] rand_extent();
    case ($urandom_range(9))
      0, 1, 2, 3, 4, 5: return 16'($urandom_range(1, 9));
      6, 7:             return 16'($urandom_range(1, 300));
      8:                return 16'($urandom);
      default:          return ($urandom_range(1)) ? 16'd0 : 16'hFFFF;
    endcase
  endfunction

  function automatic logic [15:0] rand_chunk(logic [15:0] ext);
    case ($urandom_range(7))
      0, 1:    return ext;
      2:       return 16'd0;
      3:       return 16'($urandom);
      default: return 16'($urandom_range(1, (ext == 16'd0) ? 9 : int'(ext)));
    endcase
  endfunction

  function automatic logic [31:0] rand_flat();
    case ($urandom_range(9))
      0, 1, 2, 3, 4: return $urandom_range(0, 2000);
      5, 6:          return $urandom_range(0, 50);
      default:       return $urandom;
    endcase
  endfunction

  // Driver: requests from the pending queue, register writes only when idle.
  always @(posedge clk) begin
    logic   nxt_start, nxt_we;
    entry_t e;
    nxt_start = 1'b0;
    nxt_we = 1'b0;
    if (!rst_n) begin
      start <= 1'b0;
      cfg_we <= 1'b0;
    end else begin
      if (start && !busy) begin
        e = pending_q.pop_front();
        idle_cyc = 0;
        if (e.op == fico_pkg::OP_LOAD) begin
          ext_tab[e.slot] = e.ext;
          chk_tab[e.slot] = e.chk;
          outer_tab[e.slot] = e.outer;
          inner_tab[e.slot] = e.inner;
        end else begin
          offset_q.push_back(chunked_offset(e.flat));
        end
      end else begin
        idle_cyc++;
      end
      if (pending_q.size() > 0) begin
        e = pending_q[0];
        case (e.kind)
          K_REQ: begin
            if ($urandom_range(99) >= gap_pct) begin
              nxt_start = 1'b1;
              in_op <= e.op;
              in_dim_slot <= e.slot;
              in_dim_extent <= e.ext;
              in_chunk_extent <= e.chk;
              in_outer_stride <= e.outer;
              in_inner_stride <= e.inner;
              in_flat_index <= e.flat;
            end
          end
          K_CFG: begin
            if (offset_q.size() == 0 && idle_cyc >= DRAIN_CYCLES) begin
              nxt_we = 1'b1;
              cfg_wdata <= 3'(e.val);
              dims_reg = 3'(e.val);
              void'(pending_q.pop_front());
            end
          end
          K_PAUSE: begin
            if (offset_q.size() == 0) void'(pending_q.pop_front());
          end
          default: begin
            gap_pct = e.val;
            void'(pending_q.pop_front());
          end
        endcase
      end
      start <= nxt_start;
      cfg_we <= nxt_we;
    end
  end

  // Monitor: every strobed result is checked against the oldest expectation.
  always @(posedge clk) begin
    logic [31:0] want;
    if (rst_n && out_valid) begin
      if (offset_q.size() == 0) begin
        report("unexpected result", out_offset, 32'h0);
      end else begin
        want = offset_q.pop_front();
        if (out_offset !== want) report("offset", out_offset, want);
      end
    end
  end

  // Watchdog on cycles with no accepted request, register write or result.
  always @(posedge clk) begin
    if ((start && !busy) || out_valid || cfg_we) stall_cyc <= 0;
    else stall_cyc <= stall_cyc + 1;
    if (stall_cyc >= WATCHDOG_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    int dims_list[8] = '{4, 0, 1, 7, 2, 3, 5, 6};
    int gaps[3] = '{0, 72, 32};
    logic [15:0] ext;

    // Directed part: empty shape, special extents, clamping, stride extremes.
    push_ctrl(K_CFG, 0);
    push_compute(32'hFFFF_FFFF);
    push_load(2'd0, 16'hFFFF, 16'd1, 32'h7FFF_FFFF, 32'h8000_0000);
    push_load(2'd1, 16'd0, 16'd7, 32'hFFFF_FFFF, 32'd3);
    push_load(2'd2, 16'd10, 16'd0, 32'd5, 32'hFFFF_FFF9);
    push_load(2'd3, 16'd12, 16'd12, 32'd100, 32'd1);
    push_ctrl(K_CFG, 4);
    push_compute(32'd0);
    push_compute(32'hFFFF_FFFF);
    push_compute(32'd12345);
    push_compute(32'd119);
    push_compute(32'h8000_0000);
    push_ctrl(K_CFG, 7);
    push_compute(32'd987654);
    push_compute(32'hFFFF_FFFF);
    push_load(2'd3, 16'hFFFF, 16'hFFFF, 32'h8000_0000, 32'h7FFF_FFFF);
    push_load(2'd2, 16'd1, 16'd1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    push_compute(32'hFFFF_FFFF);
    push_compute(32'd65534);
    push_ctrl(K_CFG, 1);
    push_compute(32'd65535);
    push_compute(32'hDEAD_BEEF);

    // Random phases: each sets a shape, then mostly computes against it.
    for (int ph = 0; ph < 12; ph++) begin
      push_ctrl(K_GAP, gaps[ph % 3]);
      push_ctrl(K_CFG, (ph < 8) ? dims_list[ph] : int'($urandom_range(0, 7)));
      for (int i = 0; i < 152; i++) begin
        if (i == 76 && ph == 4) push_ctrl(K_PAUSE, 0);
        if ($urandom_range(3) == 0) begin
          ext = rand_extent();
          push_load(2'($urandom), ext, rand_chunk(ext), $urandom, $urandom);
        end else begin
          push_compute(rand_flat());
        end
      end
    end

    // Hold reset, then release it and run until all requests and results are done.
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    while (pending_q.size() > 0 || offset_q.size() > 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/fico_pkg.sv
rtl/fico_dim.sv
rtl/flat_index_to_chunked_offset.sv
bench/tb_top.sv
